/* hw/rtl/clbp_pkg.sv */
`timescale 1ns / 1ps

package clbp_pkg;

    // circle geometry is fixed: radius 1, eight sample points
    localparam int RADIUS    = 1;
    localparam int NEIGHBORS = 8;
    localparam int WIN       = 2 * RADIUS + 1;
    localparam int LINES     = 2 * RADIUS;
    localparam int SLOT_W    = $clog2(LINES);
    localparam int WIN_IW    = $clog2(WIN);
    localparam int CODE_W    = 8;
    localparam int PIX_W     = 16;
    localparam int CFG_W     = 11;
    localparam int ROW_W     = 10;
    localparam int SUM_W     = PIX_W + 11;
    localparam int MAX_HEIGHT = 1024;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

    // register indexes on the configuration port
    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic signed [PIX_W-1:0] t_pixel;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic [8:0]              t_weight;
    typedef logic [WIN_IW-1:0]       t_win_idx;
    typedef t_pixel                  t_column [WIN];
    typedef t_pixel                  t_window [WIN][WIN];

    typedef struct packed {
        logic valid;
        logic emit;
        logic frame_end;
    } t_stage;

    // window indexes (row, column) of the four taps of each sample point:
    // floor row / floor column / ceiling row / ceiling column
    localparam t_win_idx PT_ROW_F [NEIGHBORS] = '{2'd1, 2'd0, 2'd0, 2'd0,
                                                  2'd1, 2'd1, 2'd2, 2'd1};
    localparam t_win_idx PT_COL_F [NEIGHBORS] = '{2'd2, 2'd1, 2'd1, 2'd0,
                                                  2'd0, 2'd0, 2'd1, 2'd1};
    localparam t_win_idx PT_ROW_C [NEIGHBORS] = '{2'd1, 2'd1, 2'd0, 2'd1,
                                                  2'd1, 2'd2, 2'd2, 2'd2};
    localparam t_win_idx PT_COL_C [NEIGHBORS] = '{2'd2, 2'd2, 2'd1, 2'd1,
                                                  2'd0, 2'd1, 2'd1, 2'd2};

    // bilinear weights, 8 fraction bits, each set sums to 256
    localparam t_weight PT_W1 [NEIGHBORS] = '{9'd256, 9'd53,  9'd256, 9'd128,
                                              9'd256, 9'd53,  9'd256, 9'd22};
    localparam t_weight PT_W2 [NEIGHBORS] = '{9'd0,   9'd128, 9'd0,   9'd53,
                                              9'd0,   9'd22,  9'd0,   9'd53};
    localparam t_weight PT_W3 [NEIGHBORS] = '{9'd0,   9'd22,  9'd0,   9'd53,
                                              9'd0,   9'd128, 9'd0,   9'd53};
    localparam t_weight PT_W4 [NEIGHBORS] = '{9'd0,   9'd53,  9'd0,   9'd22,
                                              9'd0,   9'd53,  9'd0,   9'd128};

    function automatic t_sum weigh(t_weight w, t_pixel p);
        t_sum ws;
        t_sum ps;
        ws = t_sum'($signed({1'b0, w}));
        ps = t_sum'(p);
        return ws * ps;
    endfunction

endpackage

/* hw/rtl/circular_lbp_operator.sv */
`timescale 1ns / 1ps
// circular LBP, radius 1, 8 points, one pixel in and at most one code out per cycle
// a code is valid once its pixel has passed the line store read, the window shift
// through the column cells, the weighted sums and the compare into the output
// throughput: 1 pixel per cycle; input stalls only while the output skid stage is full
// reset: synchronous active low; registers to 640 x 480, counters and window cleared,
// line store contents undefined until written, no clearing pass
module circular_lbp_operator
    import clbp_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [PIX_W-1:0]  i_pixel,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CODE_W-1:0] o_pattern_code,
    output logic              o_frame_end,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

    logic [CFG_W-1:0] r_line_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;

    logic [WW-1:0]    w_width;
    logic [CFG_W-1:0] w_height;
    logic [WW-1:0]    w_col_inc;
    logic [CFG_W-1:0] w_row_inc;
    logic             w_emit;
    logic             w_last;

    logic             w_en;
    logic             w_accept;
    t_stage           r_s1;
    t_stage           r_s2;
    t_stage           r_s3;
    t_pixel           r_s1_px;

    t_pixel           w_rows [LINES];
    t_column          w_new_col;
    t_column          w_cell_col [WIN];
    t_window          w_win;
    logic [CODE_W-1:0] w_code;

    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_fe;
    logic              r_skid_valid;
    logic [CODE_W-1:0] r_skid_code;
    logic              r_skid_fe;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LINE_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_LINE_WIDTH:   r_line_width   <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LINE_WIDTH:   prdata = {{(32 - CFG_W){1'b0}}, r_line_width};
            REG_FRAME_HEIGHT: prdata = {{(32 - CFG_W){1'b0}}, r_frame_height};
            default:          prdata = '0;
        endcase
    end

    // clamped frame geometry
    always_comb begin
        if (r_line_width == '0) begin
            w_width = WW'(1);
        end else if (WW'(r_line_width) > WW'(MAX_WIDTH)) begin
            w_width = WW'(MAX_WIDTH);
        end else begin
            w_width = WW'(r_line_width);
        end
        if (r_frame_height == '0) begin
            w_height = CFG_W'(1);
        end else if (r_frame_height > CFG_W'(MAX_HEIGHT)) begin
            w_height = CFG_W'(MAX_HEIGHT);
        end else begin
            w_height = r_frame_height;
        end
    end

    // raster position
    assign w_col_inc = WW'(r_col) + WW'(1);
    assign w_row_inc = CFG_W'(r_row) + CFG_W'(1);
    assign w_emit    = (r_row >= ROW_W'(LINES)) && (r_col >= CW'(LINES));
    assign w_last    = (w_row_inc >= w_height) && (w_col_inc >= w_width);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_col_inc >= w_width) begin
            n_col = '0;
            n_row = (w_row_inc >= w_height) ? '0 : w_row_inc[ROW_W-1:0];
        end else begin
            n_col = w_col_inc[CW-1:0];
        end
    end

    assign w_en       = !r_skid_valid;
    assign w_accept   = i_in_valid && w_en;
    assign o_in_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // control pipeline, all stages move together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (w_en) begin
            r_s1.valid     <= w_accept;
            r_s1.emit      <= w_emit;
            r_s1.frame_end <= w_last;
            r_s2.valid     <= r_s1.valid && r_s1.emit;
            r_s2.emit      <= r_s1.emit;
            r_s2.frame_end <= r_s1.frame_end;
            r_s3           <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_px <= i_pixel;
        end
    end

    clbp_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_wr   (w_accept),
        .i_addr (r_col),
        .i_slot (SLOT_W'(r_row % LINES)),
        .i_px   (i_pixel),
        .o_rows (w_rows)
    );

    // new column: stored rows oldest first, then the incoming pixel
    always_comb begin
        for (int k = 0; k < LINES; k++) begin
            w_new_col[k] = w_rows[k];
        end
        w_new_col[LINES] = r_s1_px;
    end

    // cell k holds window column WIN-1-k
    for (genvar k = 0; k < WIN; k++) begin : g_cells
        if (k == 0) begin : g_head
            clbp_col_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_en && r_s1.valid),
                .i_col   (w_new_col),
                .o_col   (w_cell_col[k])
            );
        end else begin : g_body
            clbp_col_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_en && r_s1.valid),
                .i_col   (w_cell_col[k-1]),
                .o_col   (w_cell_col[k])
            );
        end
    end

    always_comb begin
        for (int k = 0; k < WIN; k++) begin
            for (int r = 0; r < WIN; r++) begin
                w_win[r][WIN-1-k] = w_cell_col[k][r];
            end
        end
    end

    clbp_code_unit u_code_unit (
        .i_clk  (i_clk),
        .i_en   (w_en && r_s2.valid),
        .i_win  (w_win),
        .o_code (w_code)
    );

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_en && r_s3.valid;
            end
        end else if (w_en && r_s3.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_code <= r_skid_code;
                r_out_fe   <= r_skid_fe;
            end else begin
                r_out_code <= w_code;
                r_out_fe   <= r_s3.frame_end;
            end
        end else if (w_en && r_s3.valid) begin
            r_skid_code <= w_code;
            r_skid_fe   <= r_s3.frame_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pattern_code = r_out_code;
    assign o_frame_end    = r_out_fe;

endmodule

/* hw/rtl/clbp_line_store.sv */
`timescale 1ns / 1ps

module clbp_line_store
    import clbp_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_wr,
    input  logic [CW-1:0]     i_addr,
    input  logic [SLOT_W-1:0] i_slot,
    input  t_pixel            i_px,
    output t_pixel            o_rows [LINES]
);

    t_pixel            mem [LINES][MAX_WIDTH];
    t_pixel            r_rd [LINES];
    logic [SLOT_W-1:0] r_slot;

    // every slot is read at the column, the current row's slot is written
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            for (int s = 0; s < LINES; s++) begin
                if (i_slot == SLOT_W'(s)) begin
                    mem[s][i_addr] <= i_px;
                end
                r_rd[s] <= mem[s][i_addr];
            end
            r_slot <= i_slot;
        end
    end

    // oldest row first
    always_comb begin
        for (int k = 0; k < LINES; k++) begin
            o_rows[k] = r_rd[SLOT_W'((int'(r_slot) + k) % LINES)];
        end
    end

endmodule

/* hw/rtl/clbp_col_cell.sv */
`timescale 1ns / 1ps

module clbp_col_cell
    import clbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_shift,
    input  t_column i_col,
    output t_column o_col
);

    t_column r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN; k++) begin
                r_col[k] <= '0;
            end
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

/* hw/rtl/clbp_code_unit.sv */
`timescale 1ns / 1ps

module clbp_code_unit
    import clbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  t_window           i_win,
    output logic [CODE_W-1:0] o_code
);

    t_sum r_sum [NEIGHBORS];
    t_sum r_centre;
    t_sum n_sum [NEIGHBORS];

    always_comb begin
        for (int n = 0; n < NEIGHBORS; n++) begin
            n_sum[n] = weigh(PT_W1[n], i_win[PT_ROW_F[n]][PT_COL_F[n]])
                     + weigh(PT_W2[n], i_win[PT_ROW_F[n]][PT_COL_C[n]])
                     + weigh(PT_W3[n], i_win[PT_ROW_C[n]][PT_COL_F[n]])
                     + weigh(PT_W4[n], i_win[PT_ROW_C[n]][PT_COL_C[n]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum    <= n_sum;
            r_centre <= t_sum'(i_win[RADIUS][RADIUS]) <<< 8;
        end
    end

    // points beyond the code width are dropped
    always_comb begin
        o_code = '0;
        for (int n = 0; n < NEIGHBORS; n++) begin
            if (n < CODE_W) begin
                o_code[n] = (r_sum[n] >= r_centre);
            end
        end
    end

endmodule
